FILE: hw/rtl/bsort_pkg.sv
// Package: constants, types and state codes shared by the byte sorter files.
`timescale 1ns / 1ps
`default_nettype none

package bsort_pkg;

  localparam int CAPACITY = 16;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // Per-cycle command broadcast to every cell in the chain.
  typedef struct packed {
    logic  insert;
    logic  shift;
    byte_t din;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bsort_ifs.sv
// Interfaces: input byte channel and sorted result channel.
`timescale 1ns / 1ps
`default_nettype none

interface bsort_in_if;
  logic                          valid;
  logic                          ready;
  logic [bsort_pkg::BYTE_W-1:0]  data_byte;
  logic                          last_flag;

  modport source (output valid, output data_byte, output last_flag, input ready);
  modport sink   (input valid, input data_byte, input last_flag, output ready);
endinterface

interface bsort_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsort_pkg::BYTE_W-1:0]  sorted_byte;
  logic                          end_of_run;
  logic                          overflow;

  modport source (output valid, output sorted_byte, output end_of_run, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_byte, input end_of_run, input overflow,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bsort_cell.sv
// Sorter cell: one stored byte; insert from left neighbor or din, shift from right one.
`timescale 1ns / 1ps
`default_nettype none

module bsort_cell (
  input  wire                     clk,
  input  bsort_pkg::cell_ctrl_t   ctrl,
  input  wire                     occupied,
  input  wire                     left_gt,
  input  bsort_pkg::byte_t        left_val,
  input  bsort_pkg::byte_t        right_val,
  output bsort_pkg::byte_t        val,
  output logic                    gt
);
  import bsort_pkg::*;

  byte_t val_r;
  byte_t val_nxt;

  assign val = val_r;
  assign gt  = occupied && (val_r > ctrl.din);

  always_comb begin
    val_nxt = val_r;
    if (ctrl.insert) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt || !occupied) begin
        val_nxt = ctrl.din;
      end
    end else if (ctrl.shift) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bsort_chain.sv
// Sorter chain: row of cells kept in ascending order, head cell is the smallest byte.
`timescale 1ns / 1ps
`default_nettype none

module bsort_chain (
  input  wire                    clk,
  input  bsort_pkg::cell_ctrl_t  ctrl,
  input  bsort_pkg::cnt_t        count,
  output bsort_pkg::byte_t       head
);
  import bsort_pkg::*;

  byte_t             vals [CAPACITY];
  logic [CAPACITY-1:0] gts;
  logic [CAPACITY-1:0] occ;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    byte_t left_val;
    byte_t right_val;
    logic  left_gt;

    assign occ[i] = cnt_t'(i) < count;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = vals[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    bsort_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ[i]),
      .left_gt   (left_gt),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (vals[i]),
      .gt        (gts[i])
    );
  end

  assign head = vals[0];

endmodule

`default_nettype wire

FILE: hw/rtl/byte_array_sorter_core.sv
// Top level: byte run loader and sorted drain around an insertion chain.
//
//   channel   dir  beat contents
//   in_bus    in   data_byte[7:0], last_flag
//   out_bus   out  sorted_byte[7:0], end_of_run, overflow
//
// Load: one byte per cycle; each byte is inserted into the chain as it is accepted.
// After last_flag, n beats drain from the head cell, one per cycle while ready is high.
// in_bus.ready is low while a run drains; bytes past CAPACITY are dropped and flagged.
// Reset clears state, count and overflow flag; cell contents are not reset.
// Output stalls hold the head cell and the count.
`timescale 1ns / 1ps
`default_nettype none

module byte_array_sorter_core (
  input  wire              clk,
  input  wire              rst_n,
  bsort_in_if.sink         in_bus,
  bsort_out_if.source      out_bus
);
  import bsort_pkg::*;

  state_t     state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  logic       ovf_r, ovf_nxt;
  cell_ctrl_t ctrl;
  byte_t      head;
  logic       in_fire;
  logic       out_fire;
  logic       full;

  assign in_bus.ready        = (state_r == ST_LOAD);
  assign out_bus.valid       = (state_r == ST_DRAIN);
  assign out_bus.sorted_byte = head;
  assign out_bus.end_of_run  = (count_r == cnt_t'(1));
  assign out_bus.overflow    = ovf_r;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_bus.valid && out_bus.ready;
  assign full     = (count_r == cnt_t'(CAPACITY));

  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = out_fire;
  assign ctrl.din    = in_bus.data_byte;

  bsort_chain u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .count (count_r),
    .head  (head)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + cnt_t'(1);
          end
          if (in_bus.last_flag) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          count_nxt = count_r - cnt_t'(1);
          if (count_r == cnt_t'(1)) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (count_r != '0))
    else $error("drain with empty chain");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(CAPACITY))
    else $error("count past capacity");

  a_run_end_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_bus.end_of_run) |=> (in_bus.ready && count_r == '0 && !ovf_r))
    else $error("run end did not return to load");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_bus.last_flag) |=> out_bus.valid)
    else $error("last beat did not start drain");
`endif

endmodule

`default_nettype wire

FILE: test/byte_array_sorter_core_tb.sv
// Testbench: byte_array_sorter_core with a sorted-run predictor and random handshake idling.
`timescale 1ns / 1ps

module byte_array_sorter_core_tb;
  import bsort_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    byte_t sorted_byte;
    logic  end_of_run;
    logic  overflow;
  } sorted_beat_t;

  // Holds the current run in ascending order as bytes arrive; queues and checks the result beats.
  class sorted_run_board;
    byte_t        held[CAPACITY];
    int           held_n;
    bit           run_overflow;
    sorted_beat_t sorted_q[$];
    int           errors;

    function new();
      held_n       = 0;
      run_overflow = 0;
      errors       = 0;
    endfunction

    function void note_beat(byte_t val, logic last);
      int           i;
      sorted_beat_t e;
      if (held_n < CAPACITY) begin
        i = held_n;
        while (i > 0 && held[i-1] > val) begin
          held[i] = held[i-1];
          i--;
        end
        held[i] = val;
        held_n++;
      end else begin
        run_overflow = 1;
      end
      if (last) begin
        for (i = 0; i < held_n; i++) begin
          e.sorted_byte = held[i];
          e.end_of_run  = (i == held_n - 1);
          e.overflow    = run_overflow;
          sorted_q.push_back(e);
        end
        held_n       = 0;
        run_overflow = 0;
      end
    endfunction

    function void check_result(byte_t val, logic eor, logic ovf);
      sorted_beat_t e;
      if (sorted_q.size() == 0) begin
        $error("unexpected result beat: sorted_byte %0d end_of_run %0b overflow %0b",
               val, eor, ovf);
        errors++;
        return;
      end
      e = sorted_q.pop_front();
      if (val !== e.sorted_byte) begin
        $error("sorted_byte: expected %0d, got %0d", e.sorted_byte, val);
        errors++;
      end
      if (eor !== e.end_of_run) begin
        $error("end_of_run: expected %0b, got %0b", e.end_of_run, eor);
        errors++;
      end
      if (ovf !== e.overflow) begin
        $error("overflow: expected %0b, got %0b", e.overflow, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return sorted_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  int   stall_cycles;
  int   items;

  bsort_in_if  in_bus();
  bsort_out_if out_bus();

  sorted_run_board board = new();

  byte_array_sorter_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Beat monitor, result check and stall watchdog.
  always @(posedge clk) begin
    if (in_bus.valid && in_bus.ready)
      board.note_beat(in_bus.data_byte, in_bus.last_flag);
    if (out_bus.valid && out_bus.ready)
      board.check_result(out_bus.sorted_byte, out_bus.end_of_run, out_bus.overflow);
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("byte_array_sorter_core: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random stall bursts while idle_on is set.
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input byte_t val, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= val;
    in_bus.last_flag <= last;
    do @(posedge clk); while (!in_bus.ready);
    items++;
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_run();
    int    len;
    int    pick;
    int    mode;
    int    base;
    byte_t val;
    pick = $urandom_range(0, 9);
    if (pick < 7)
      len = $urandom_range(1, CAPACITY);
    else if (pick < 8)
      len = CAPACITY;
    else
      len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
    mode = $urandom_range(0, 3);
    base = $urandom_range(0, 252);
    for (int k = 0; k < len; k++) begin
      case (mode)
        0: val = byte_t'($urandom_range(0, 255));
        1: val = byte_t'(base + $urandom_range(0, 3));
        2: val = byte_t'((k * 16 + $urandom_range(0, 15)) & 8'hff);
        default: val = byte_t'(8'hff - ((k * 16 + $urandom_range(0, 15)) & 8'hff));
      endcase
      send_beat(val, k == len - 1);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= '0;
    in_bus.last_flag <= 1'b0;
    idle_on          = 1'b1;
    stall_cycles     = 0;
    items            = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-byte runs at both extremes
    send_beat(8'h00, 1'b1);
    send_beat(8'hff, 1'b1);
    // duplicates and zero in mid-run
    send_beat(8'hff, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h01, 1'b1);
    // full descending store, then the last-marked beat is dropped
    for (int k = 0; k < CAPACITY; k++)
      send_beat(byte_t'(8'hff - k * 17), 1'b0);
    send_beat(8'h42, 1'b1);
    wait_drained();

    while (items < 272) begin
      if (items > 232)
        idle_on = 1'b0;
      send_random_run();
      if ($urandom_range(0, 9) == 0)
        wait_drained();
    end
    in_bus.valid <= 1'b0;

    wait_drained();
    repeat (24) @(posedge clk);
    if (board.errors == 0 && board.held_n == 0 && board.pending() == 0)
      $display("byte_array_sorter_core: match");
    else
      $display("byte_array_sorter_core: mismatch");
    $finish;
  end

endmodule

FILE: byte_array_sorter_core.f
hw/rtl/bsort_pkg.sv
hw/rtl/bsort_ifs.sv
hw/rtl/bsort_cell.sv
hw/rtl/bsort_chain.sv
hw/rtl/byte_array_sorter_core.sv
test/byte_array_sorter_core_tb.sv
